>>> src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define OMT_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("invariant violated");

// When ante holds, cons must hold in the same cycle.
`define OMT_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication violated");

`endif

>>> src/omt_pkg.sv
// Types, codes and constants of the orientation match table.
package omt_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int THRESH_W = 15;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd15565;

   // Command codes
   localparam logic [1:0] CMD_DETECT    = 2'd0;
   localparam logic [1:0] CMD_CALIBRATE = 2'd1;
   localparam logic [1:0] CMD_CLEAR     = 2'd2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOMATCH = 2'd1,
      ST_FULL    = 2'd2,
      ST_DUP     = 2'd3
   } omt_status_type;

   typedef struct packed {
      logic        [1:0]  cmd;
      logic signed [15:0] vec_x;
      logic signed [15:0] vec_y;
      logic signed [15:0] vec_z;
   } omt_req_type;

   typedef struct packed {
      omt_status_type status;
      logic [3:0]     entry_index;
      logic [4:0]     entry_count;
   } omt_rsp_type;

   // One stored orientation
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } omt_vec_type;

   // Control into the dot product unit
   typedef struct packed {
      logic start;  // clear best-so-far
      logic valid;  // head entry takes part in this scan step
   } omt_scan_ctl_type;

endpackage

>>> src/omt_cell.sv
// One storage cell of the rotating vector chain.
module omt_cell (
   input  logic                clock,
   input  logic                wr_en,
   input  omt_pkg::omt_vec_type wr_vec,
   input  logic                shift_en,
   input  omt_pkg::omt_vec_type shift_vec,
   output omt_pkg::omt_vec_type vec
);

   omt_pkg::omt_vec_type vec_ff;

   // Load a new entry, or take the neighbor's entry during a scan
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vec_ff <= wr_vec;
      end else if (shift_en) begin
         vec_ff <= shift_vec;
      end
   end

   assign vec = vec_ff;

endmodule

>>> src/omt_dot_unit.sv
// Dot product and best-match tracker fed from the head of the cell chain.
module omt_dot_unit #(
   parameter  int MAX_ENTRIES = omt_pkg::MAX_ENTRIES_DEFAULT,
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  omt_pkg::omt_scan_ctl_type         ctl,
   input  logic [IDX_W-1:0]                  idx,
   input  omt_pkg::omt_vec_type              query,
   input  omt_pkg::omt_vec_type              entry,
   input  logic [omt_pkg::THRESH_W-1:0]      thresh,
   output logic                              matched,
   output logic [IDX_W-1:0]                  best_idx
);

   // Stage 1: three products
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic               v1_ff;
   logic [IDX_W-1:0]   i1_ff;
   // Stage 2: exact sum
   logic signed [33:0] sum_ff;
   logic               v2_ff;
   logic [IDX_W-1:0]   i2_ff;
   // Stage 3: best so far
   logic signed [33:0] best_ff;
   logic               have_ff;
   logic [IDX_W-1:0]   best_idx_ff;

   logic signed [33:0] sum_in;
   logic signed [33:0] thr_q;
   logic               take;

   assign sum_in = {{2{px_ff[31]}}, px_ff} + {{2{py_ff[31]}}, py_ff}
                 + {{2{pz_ff[31]}}, pz_ff};
   // First valid entry wins ties: only a strictly larger sum replaces it
   assign take   = v2_ff && (!have_ff || (sum_ff > best_ff));
   assign thr_q  = $signed({5'b0, thresh, 14'b0});

   // Pipeline payload
   always_ff @(posedge clock) begin
      px_ff <= $signed(query.x) * $signed(entry.x);
      py_ff <= $signed(query.y) * $signed(entry.y);
      pz_ff <= $signed(query.z) * $signed(entry.z);
      i1_ff <= idx;
      sum_ff <= sum_in;
      i2_ff <= i1_ff;
      if (take) begin
         best_ff     <= sum_ff;
         best_idx_ff <= i2_ff;
      end
   end

   // Pipeline control
   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
         if (take) begin
            have_ff <= 1'b1;
         end
      end
   end

   assign matched  = have_ff && (best_ff > thr_q);
   assign best_idx = best_idx_ff;

endmodule

>>> src/orientation_match_table.sv
// Top level of the orientation match table: command sequencer, cell chain, result register.
// A detect or calibrate item (calibrate with room left) is accepted in S_IDLE, then scans
// each table slot in turn in S_SCAN while the stored vectors rotate once around the cell
// chain past the shared dot product unit, drains its product and sum stages in S_DRAIN,
// and posts the result in S_FINISH once the output register is free. Clear, unused
// commands and calibrate on a full table go from acceptance straight to S_FINISH. The
// result sits in an output register, so a new item is taken while it waits.
// The threshold register can be written at any time the block is idle.
`include "assert_macros.svh"

module orientation_match_table #(
   parameter int MAX_ENTRIES = omt_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  omt_pkg::omt_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output omt_pkg::omt_rsp_type         rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [omt_pkg::THRESH_W-1:0] csr_data
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] ISS_LAST = CNT_W'(MAX_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   omt_pkg::omt_req_type         req_ff, req_in;
   logic [CNT_W-1:0]             iss_ff, iss_in;
   logic                         drain_ff, drain_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [omt_pkg::THRESH_W-1:0] thr_ff, thr_in;
   omt_pkg::omt_rsp_type         rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   omt_pkg::omt_vec_type         query;
   omt_pkg::omt_vec_type         cell_vec [MAX_ENTRIES];
   omt_pkg::omt_scan_ctl_type    scan_ctl;
   logic                         matched;
   logic [IDX_W-1:0]             best_idx;
   logic                         store_en;
   logic                         rotate;
   logic                         accept;
   logic                         slot_free;
   logic [IDX_W+3:0]             best_idx_wide;
   logic [CNT_W+3:0]             count_idx_wide;
   logic [CNT_W+4:0]             count_out_wide;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rotate    = (state_ff == S_SCAN);

   assign query.x = req_ff.vec_x;
   assign query.y = req_ff.vec_y;
   assign query.z = req_ff.vec_z;

   // Rotating chain of storage cells; cell 0 is the head
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      localparam int NXT = (i + 1) % MAX_ENTRIES;
      omt_cell u_cell (
         .clock     (clock),
         .wr_en     (store_en && (count_ff == CNT_W'(i))),
         .wr_vec    (query),
         .shift_en  (rotate),
         .shift_vec (cell_vec[NXT]),
         .vec       (cell_vec[i])
      );
   end

   assign scan_ctl.start = accept;
   assign scan_ctl.valid = rotate && (iss_ff < count_ff);

   omt_dot_unit #(.MAX_ENTRIES(MAX_ENTRIES)) u_dot (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .idx      (iss_ff[IDX_W-1:0]),
      .query    (query),
      .entry    (cell_vec[0]),
      .thresh   (thr_ff),
      .matched  (matched),
      .best_idx (best_idx)
   );

   assign best_idx_wide  = {4'b0, best_idx};
   assign count_idx_wide = {4'b0, count_ff};

   // Calibrate stores only when there is room and no existing match
   assign store_en = (state_ff == S_FINISH) && slot_free
                  && (req_ff.cmd == omt_pkg::CMD_CALIBRATE)
                  && (count_ff < CNT_MAX) && !matched;

   // Sequencer next state and result formation
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      iss_in         = iss_ff;
      drain_in       = drain_ff;
      count_in       = count_ff;
      thr_in         = thr_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      count_out_wide = '0;

      if (csr_valid) begin
         thr_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               iss_in   = '0;
               drain_in = 1'b0;
               if ((req_data.cmd == omt_pkg::CMD_DETECT)
                   || ((req_data.cmd == omt_pkg::CMD_CALIBRATE) && (count_ff < CNT_MAX))) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            iss_in = iss_ff + 1'b1;
            if (iss_ff == ISS_LAST) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_in.status      = omt_pkg::ST_OK;
               rsp_in.entry_index = 4'd0;
               case (req_ff.cmd)
                  omt_pkg::CMD_DETECT: begin
                     if (matched) begin
                        rsp_in.entry_index = best_idx_wide[3:0];
                     end else begin
                        rsp_in.status = omt_pkg::ST_NOMATCH;
                     end
                  end
                  omt_pkg::CMD_CALIBRATE: begin
                     if (count_ff >= CNT_MAX) begin
                        rsp_in.status = omt_pkg::ST_FULL;
                     end else if (matched) begin
                        rsp_in.status = omt_pkg::ST_DUP;
                     end else begin
                        rsp_in.entry_index = count_idx_wide[3:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  omt_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               // entry_count reflects the count after this item
               count_out_wide     = {5'b0, count_in};
               rsp_in.entry_count = count_out_wide[4:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         thr_ff       <= omt_pkg::THRESH_RESET;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
         drain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_ff       <= iss_in;
         drain_ff     <= drain_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   // Checks on the table bookkeeping
   `OMT_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_MAX)
   `OMT_ASSERT_IMPLY(a_store_room, store_en, (count_ff < CNT_MAX) && (state_ff == S_FINISH))
   `OMT_ASSERT_IMPLY(a_match_in_table, (state_ff == S_FINISH) && matched,
                     {1'b0, best_idx} < {1'b0, count_ff})

endmodule
